// ===== sv/ppm_sum_frame_generator_unit_macros.svh =====
// Assertion macros shared by the PPM sum frame generator RTL.
`ifndef PPM_SUM_FRAME_GENERATOR_UNIT_MACROS_SVH
`define PPM_SUM_FRAME_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define PPMSFG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("PPM sum frame generator check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define PPMSFG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("PPM sum frame generator check failed");

`endif

// ===== sv/ppmsfg_pkg.sv =====
// Types and constants of the PPM sum frame generator.
package ppmsfg_pkg;

    typedef enum logic [1:0] {
        MODE_SYNC = 2'd0,
        MODE_LOW  = 2'd1,
        MODE_HIGH = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        CFG_FRAME_TICKS  = 3'd0,
        CFG_LOW_TICKS    = 3'd1,
        CFG_MIN_US       = 3'd2,
        CFG_MAX_US       = 3'd3,
        CFG_TICKS_PER_US = 3'd4
    } cfg_idx_t;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [15:0] FRAME_TICKS_RST  = 16'd45000;
    localparam logic [15:0] LOW_TICKS_RST    = 16'd600;
    localparam logic [15:0] MIN_US_RST       = 16'd1000;
    localparam logic [15:0] MAX_US_RST       = 16'd2000;
    localparam logic [4:0]  TICKS_PER_US_RST = 5'd2;

endpackage

// ===== sv/ppm_sum_frame_generator_unit.sv =====
// Top level of the PPM sum frame generator: channel table, tick sequencer and result register.
//
// Each input word is either one timer tick (operation = tick) or a write of one
// channel's width in microseconds. Every accepted word yields exactly one result
// word carrying the PPM pin level after that word, a clip flag for writes and a
// frame start flag for the tick that opens a new frame.
// Configuration registers are written over a separate valid/ready channel that is
// always ready; writes should only occur while the block is idle.
// The result is registered: the word accepted at one edge is presented at out_* from
// the next cycle on. Throughput is one word per cycle while the receiver does not
// stall, set by the single registered pass through the counter compare and the
// channel slot add, or through the clamp and the 16 by 5 bit multiply for a write.
// If the receiver stalls, the result register holds its word and in_ready falls;
// it rises again in the cycle the result is taken, so no cycle is lost.
// Reset (asynchronous, active low) loads the default configuration, fills every
// channel slot with the center width minus the separator width, starts in the
// sync gap with the pin high, and empties the result register.
`include "ppm_sum_frame_generator_unit_macros.svh"

module ppm_sum_frame_generator_unit
    import ppmsfg_pkg::*;
#(
    parameter int NUM_CHANNELS = 8,
    parameter int CENTER_TICKS = 3000
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [2:0]  channel,
    input  logic [15:0] width_us,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        pin_level,
    output logic        clipped,
    output logic        frame_start,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [15:0] SLOT_RST =
        (CENTER_TICKS > int'(LOW_TICKS_RST)) ?
        16'(CENTER_TICKS - int'(LOW_TICKS_RST)) : 16'd0;

    logic [15:0] frame_ticks_reg;
    logic [15:0] low_ticks_reg;
    logic [15:0] min_us_reg;
    logic [15:0] max_us_reg;
    logic [4:0]  ticks_per_us_reg;

    logic [15:0] table_reg [NUM_CHANNELS];

    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] next_channel_reg, next_channel_next;
    logic [15:0]      counter_reg, counter_next;
    logic [15:0]      compare_reg, compare_next;
    logic             level_reg, level_next;

    logic out_valid_reg, out_valid_next;
    logic pin_level_reg;
    logic clipped_reg, clipped_next;
    logic frame_start_reg, frame_start_next;

    logic        in_accept;
    logic        is_tick;
    logic        is_write;
    logic [4:0]  channel_ext;
    logic [15:0] counter_inc;
    logic        match;
    logic        channels_done;
    logic [15:0] slot_value;
    logic [15:0] clamp_max;
    logic [15:0] clamp_us;
    logic        clip_hi;
    logic        clip_lo;
    logic [20:0] product;
    logic [20:0] diff;
    logic [15:0] slot_new;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign channel_ext = {2'b00, channel};
    assign is_tick  = in_accept && (operation == OP_TICK);
    assign is_write = in_accept && (operation == OP_WRITE)
                      && (channel_ext < 5'(NUM_CHANNELS));

    assign counter_inc   = counter_reg + 16'd1;
    assign match         = (counter_inc == compare_reg);
    assign channels_done = (next_channel_reg >= CNT_W'(NUM_CHANNELS));
    assign slot_value    = channels_done ? 16'd0 : table_reg[next_channel_reg[IDX_W-1:0]];

    assign clip_hi   = (width_us > max_us_reg);
    assign clamp_max = clip_hi ? max_us_reg : width_us;
    assign clip_lo   = (clamp_max < min_us_reg);
    assign clamp_us  = clip_lo ? min_us_reg : clamp_max;
    assign product   = 21'(clamp_us) * 21'(ticks_per_us_reg);
    assign diff      = product - 21'(low_ticks_reg);
    assign slot_new  = (product <= 21'(low_ticks_reg)) ? 16'd0 :
                       (diff > 21'h00FFFF) ? 16'hFFFF : diff[15:0];

    always_comb
    begin
        mode_next         = mode_reg;
        next_channel_next = next_channel_reg;
        counter_next      = counter_reg;
        compare_next      = compare_reg;
        level_next        = level_reg;
        frame_start_next  = 1'b0;
        if (is_tick)
        begin
            counter_next = counter_inc;
            if (match)
            begin
                case (mode_reg)
                    MODE_SYNC:
                    begin
                        level_next        = 1'b0;
                        counter_next      = 16'd0;
                        next_channel_next = '0;
                        compare_next      = low_ticks_reg;
                        mode_next         = MODE_LOW;
                        frame_start_next  = 1'b1;
                    end
                    MODE_LOW:
                    begin
                        level_next = 1'b1;
                        if (channels_done)
                        begin
                            compare_next = frame_ticks_reg;
                            mode_next    = MODE_SYNC;
                        end
                        else
                        begin
                            compare_next      = compare_reg + slot_value;
                            next_channel_next = next_channel_reg + CNT_W'(1);
                            mode_next         = MODE_HIGH;
                        end
                    end
                    default:
                    begin
                        level_next   = 1'b0;
                        compare_next = compare_reg + low_ticks_reg;
                        mode_next    = MODE_LOW;
                    end
                endcase
            end
        end
        clipped_next   = is_write && (clip_hi || clip_lo);
        out_valid_next = in_accept || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ticks_reg  <= FRAME_TICKS_RST;
            low_ticks_reg    <= LOW_TICKS_RST;
            min_us_reg       <= MIN_US_RST;
            max_us_reg       <= MAX_US_RST;
            ticks_per_us_reg <= TICKS_PER_US_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FRAME_TICKS:  frame_ticks_reg  <= cfg_data;
                CFG_LOW_TICKS:    low_ticks_reg    <= cfg_data;
                CFG_MIN_US:       min_us_reg       <= cfg_data;
                CFG_MAX_US:       max_us_reg       <= cfg_data;
                CFG_TICKS_PER_US: ticks_per_us_reg <= cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                table_reg[i] <= SLOT_RST;
            end
        end
        else if (is_write)
        begin
            table_reg[channel_ext[IDX_W-1:0]] <= slot_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_SYNC;
            next_channel_reg <= '0;
            counter_reg      <= 16'd0;
            compare_reg      <= FRAME_TICKS_RST;
            level_reg        <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            mode_reg         <= mode_next;
            next_channel_reg <= next_channel_next;
            counter_reg      <= counter_next;
            compare_reg      <= compare_next;
            level_reg        <= level_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pin_level_reg   <= level_next;
            clipped_reg     <= clipped_next;
            frame_start_reg <= frame_start_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pin_level   = pin_level_reg;
    assign clipped     = clipped_reg;
    assign frame_start = frame_start_reg;

    `PPMSFG_ASSERT_NOW(a_start_drives_low, out_valid_reg && frame_start_reg, !pin_level_reg)
    `PPMSFG_ASSERT_NOW(a_clip_not_start, out_valid_reg && clipped_reg, !frame_start_reg)
    `PPMSFG_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid_reg)
    `PPMSFG_ASSERT_NEXT(a_sync_step, is_tick && match && (mode_reg == MODE_SYNC), (mode_reg == MODE_LOW) && (counter_reg == 16'd0) && (next_channel_reg == '0))
    `PPMSFG_ASSERT_NOW(a_channel_bound, 1'b1, next_channel_reg <= CNT_W'(NUM_CHANNELS))

endmodule

// ===== test/tb.sv =====
// Testbench of the PPM sum frame generator: predicts every result word and checks it.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppmsfg_pkg::*;

    localparam int NUM_CH = 8;
    localparam int CENTER_TICKS = 3000;

    typedef struct packed {
        logic pin;
        logic clip;
        logic start;
    } ppm_result_t;

    typedef struct {
        logic        op;
        logic [2:0]  ch;
        logic [15:0] us;
        ppm_result_t res;
    } ppm_word_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = OP_TICK;
    logic [2:0]  channel = 3'd0;
    logic [15:0] width_us = 16'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        pin_level;
    logic        clipped;
    logic        frame_start;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_data = 16'd0;

    ppm_sum_frame_generator_unit #(
        .NUM_CHANNELS(NUM_CH),
        .CENTER_TICKS(CENTER_TICKS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .channel(channel),
        .width_us(width_us),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pin_level(pin_level),
        .clipped(clipped),
        .frame_start(frame_start),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic [15:0] cf_frame;
    logic [15:0] cf_low;
    logic [15:0] cf_min;
    logic [15:0] cf_max;
    logic [4:0]  cf_tpu;

    logic [15:0] slot_tbl [NUM_CH];
    mode_t       seq_mode;
    logic [4:0]  chan_next;
    logic [15:0] tick_count;
    logic [15:0] compare_at;
    logic        pin_state;
    logic        last_frame_start;

    ppm_word_t   pending_words [$];
    ppm_result_t due_results [$];
    ppm_word_t   held_word;
    ppm_result_t head_result;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatch_count = 0;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [15:0] slot_ticks(logic [31:0] total, logic [15:0] sub);
        logic [31:0] rest;
        if (total <= {16'd0, sub})
            return 16'd0;
        rest = total - {16'd0, sub};
        if (rest > 32'h0000_FFFF)
            return 16'hFFFF;
        return rest[15:0];
    endfunction

    task automatic reset_frame_model();
        cf_frame = FRAME_TICKS_RST;
        cf_low = LOW_TICKS_RST;
        cf_min = MIN_US_RST;
        cf_max = MAX_US_RST;
        cf_tpu = TICKS_PER_US_RST;
        for (int i = 0; i < NUM_CH; i++)
            slot_tbl[i] = slot_ticks(CENTER_TICKS, LOW_TICKS_RST);
        seq_mode = MODE_SYNC;
        chan_next = 5'd0;
        tick_count = 16'd0;
        compare_at = FRAME_TICKS_RST;
        pin_state = 1'b1;
    endtask

    task automatic advance_frame_model(input logic op, input logic [2:0] ch,
                                       input logic [15:0] us, output ppm_result_t r);
        logic [15:0] v;
        logic [31:0] prod;
        r = '0;
        if (op == OP_TICK) begin
            tick_count = tick_count + 16'd1;
            if (tick_count == compare_at) begin
                case (seq_mode)
                    MODE_SYNC: begin
                        pin_state = 1'b0;
                        tick_count = 16'd0;
                        chan_next = 5'd0;
                        compare_at = cf_low;
                        seq_mode = MODE_LOW;
                        r.start = 1'b1;
                    end
                    MODE_LOW: begin
                        pin_state = 1'b1;
                        if (chan_next >= NUM_CH) begin
                            compare_at = cf_frame;
                            seq_mode = MODE_SYNC;
                        end else begin
                            compare_at = compare_at + slot_tbl[chan_next];
                            chan_next = chan_next + 5'd1;
                            seq_mode = MODE_HIGH;
                        end
                    end
                    default: begin
                        pin_state = 1'b0;
                        compare_at = compare_at + cf_low;
                        seq_mode = MODE_LOW;
                    end
                endcase
            end
        end else if (ch < NUM_CH) begin
            v = us;
            if (v > cf_max) begin
                v = cf_max;
                r.clip = 1'b1;
            end
            if (v < cf_min) begin
                v = cf_min;
                r.clip = 1'b1;
            end
            prod = {16'd0, v};
            prod = prod * {27'd0, cf_tpu};
            slot_tbl[ch] = slot_ticks(prod, cf_low);
        end
        r.pin = pin_state;
    endtask

    task automatic send_word(input logic op, input logic [2:0] ch, input logic [15:0] us);
        ppm_word_t w;
        ppm_result_t r;
        advance_frame_model(op, ch, us, r);
        w.op = op;
        w.ch = ch;
        w.us = us;
        w.res = r;
        pending_words.push_back(w);
        last_frame_start = r.start;
    endtask

    task automatic send_tick();
        send_word(OP_TICK, 3'($urandom_range(7)), 16'($urandom_range(65535)));
    endtask

    function automatic logic [15:0] pick_width();
        int v;
        case ($urandom_range(3))
            0: v = int'($urandom_range(65535));
            1: begin
                if (cf_min <= cf_max)
                    v = int'($urandom_range(cf_max, cf_min));
                else
                    v = int'($urandom_range(65535));
            end
            2: v = int'(cf_min) + int'($urandom_range(4)) - 2;
            default: v = int'(cf_max) + int'($urandom_range(4)) - 2;
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    task automatic ticks_until_frame(input int cap);
        int n;
        n = 0;
        do begin
            send_tick();
            n++;
        end while (!last_frame_start && n < cap);
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FRAME_TICKS:  cf_frame = val;
            CFG_LOW_TICKS:    cf_low = val;
            CFG_MIN_US:       cf_min = val;
            CFG_MAX_US:       cf_max = val;
            CFG_TICKS_PER_US: cf_tpu = val[4:0];
            default: ;
        endcase
    endtask

    task automatic random_words(input int n);
        int stall_at;
        stall_at = $urandom_range(n - 1);
        for (int i = 0; i < n; i++) begin
            if (i == stall_at)
                wait_drained();
            if ($urandom_range(99) < 85)
                send_tick();
            else
                send_word(OP_WRITE, 3'($urandom_range(7)), pick_width());
        end
    endtask

    task automatic run_phase(input bit align, input logic [15:0] frame, input logic [15:0] low,
                             input logic [15:0] mn, input logic [15:0] mx,
                             input logic [4:0] tpu, input int n);
        if (align)
            ticks_until_frame(1000);
        wait_drained();
        write_reg(CFG_FRAME_TICKS, frame);
        write_reg(CFG_LOW_TICKS, low);
        write_reg(CFG_MIN_US, mn);
        write_reg(CFG_MAX_US, mx);
        write_reg(CFG_TICKS_PER_US, {11'd0, tpu});
        for (int c = 0; c < NUM_CH; c++)
            send_word(OP_WRITE, 3'(c), pick_width());
        if (n > 0)
            random_words(n);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                due_results.push_back(held_word.res);
            if (!in_valid || in_ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    operation <= held_word.op;
                    channel <= held_word.ch;
                    width_us <= held_word.us;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (due_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result word: pin %0b clip %0b start %0b",
                                 pin_level, clipped, frame_start);
                    mismatch_count++;
                end else begin
                    head_result = due_results.pop_front();
                    if (pin_level !== head_result.pin || clipped !== head_result.clip ||
                        frame_start !== head_result.start) begin
                        if (mismatch_count < 10)
                            $display("mismatch: expected pin %0b clip %0b start %0b, got pin %0b clip %0b start %0b",
                                     head_result.pin, head_result.clip, head_result.start,
                                     pin_level, clipped, frame_start);
                        mismatch_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        reset_frame_model();
        send_idle_pct = 21;
        recv_idle_pct = 56;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_tick();
        send_word(OP_WRITE, 3'd0, 16'd0);
        send_word(OP_WRITE, 3'd7, 16'hFFFF);
        send_word(OP_WRITE, 3'd1, MIN_US_RST);
        send_word(OP_WRITE, 3'd2, MAX_US_RST);
        send_word(OP_WRITE, 3'd3, MAX_US_RST + 16'd1);
        send_word(OP_WRITE, 3'd4, MIN_US_RST - 16'd1);
        send_word(OP_WRITE, 3'd5, 16'd1500);
        send_word(OP_WRITE, 3'd6, 16'h5555);
        send_word(OP_WRITE, 3'd6, 16'hAAAA);
        send_tick();

        run_phase(1'b0, 16'd150, 16'd3, 16'd4, 16'd12, 5'd1, 0);
        ticks_until_frame(50000);
        random_words(180);

        send_idle_pct = 56;
        recv_idle_pct = 21;
        run_phase(1'b1, 16'd140, 16'd2, 16'd1, 16'd3, 5'd5, 170);
        run_phase(1'b1, 16'd200, 16'd1, 16'd10, 16'd3, 5'd2, 150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(1'b1, 16'd30, 16'd2, 16'd0, 16'hFFFF, 5'd1, 0);
        send_word(OP_WRITE, 3'd0, 16'd1);
        for (int c = 1; c < NUM_CH; c++)
            send_word(OP_WRITE, 3'(c), 16'd5);
        ticks_until_frame(140000);

        run_phase(1'b0, 16'd250, 16'd1, 16'd3, 16'd9, 5'd3, 100);
        run_phase(1'b1, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0, 5'd16, 50);
        run_phase(1'b0, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 5'd16, 50);

        wait_drained();
        if (mismatch_count == 0 && due_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/ppmsfg_pkg.sv
sv/ppm_sum_frame_generator_unit.sv
test/tb.sv
